// ----- rtl/core/kdlp_pkg.sv -----
// Shared types and constants for the key debouncer with long-press detection.
`default_nettype none
package kdlp_pkg;

  // Number of agreeing scans that make a level stable, and the scan spacing.
  localparam int unsigned DEBOUNCE_COUNT   = 3;
  localparam int unsigned SCAN_INTERVAL_MS = 10;
  localparam int unsigned CNT_W            = $clog2(DEBOUNCE_COUNT + 1);

  localparam logic [31:0] LONG_PRESS_RESET = 32'd500;

  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_READ = 2'd1,
    CMD_INIT = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    EV_IDLE     = 2'd0,
    EV_PRESSED  = 2'd1,
    EV_RELEASED = 2'd2,
    EV_LONG     = 2'd3
  } event_t;

  typedef enum logic {
    REG_LONG_PRESS   = 1'b0,
    REG_PIN_INVERTED = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic        is_started;
    logic        stable_pressed;
    logic        long_seen;
    logic [31:0] press_start_ms;
    logic [31:0] last_scan_ms;
    cnt_t        settle_count;
    event_t      pending_event;
  } key_state_t;

  typedef struct packed {
    event_t event_code;
    logic   debounced_pressed;
    logic   raw_pressed;
  } key_result_t;

endpackage
`default_nettype wire

// ----- rtl/core/kdlp_step.sv -----
// Next-state and result logic for one command beat of the key debouncer.
`default_nettype none
module kdlp_step import kdlp_pkg::*; (
  input  wire logic [1:0]  cmd,
  input  wire logic [31:0] now_ms,
  input  wire logic        pin_level,
  input  wire logic [31:0] long_press_ms,
  input  wire logic        pin_inverted,
  input  wire key_state_t  st,
  output key_state_t       st_next,
  output key_result_t      res
);

  localparam cnt_t        FULL_COUNT = CNT_W'(DEBOUNCE_COUNT);
  localparam logic [31:0] SCAN_MS    = 32'(SCAN_INTERVAL_MS);

  logic        raw;
  logic [31:0] scan_diff;
  logic [31:0] hold_diff;
  logic        scan_due;
  logic        hold_ok;
  logic        ticking;
  cnt_t        cnt_n;
  logic        stable;
  event_t      ev;

  // Pending-slot priority: a press is never replaced, a long press replaces
  // anything else, and a press replaces a pending release.
  function automatic event_t post_event(event_t cur, event_t ev_in);
    event_t r;
    r = cur;
    if (cur == EV_IDLE) begin
      r = ev_in;
    end else if (cur == EV_PRESSED) begin
      r = cur;
    end else if (ev_in == EV_LONG) begin
      r = ev_in;
    end else if (cur == EV_RELEASED && ev_in == EV_PRESSED) begin
      r = ev_in;
    end
    return r;
  endfunction

  assign raw       = pin_inverted ? pin_level : !pin_level;
  assign scan_diff = now_ms - st.last_scan_ms;
  assign hold_diff = now_ms - st.press_start_ms;
  assign scan_due  = scan_diff >= SCAN_MS;
  assign hold_ok   = hold_diff >= long_press_ms;
  assign ticking   = st.is_started &&
                     (cmd_t'(cmd) == CMD_TICK || cmd_t'(cmd) == CMD_READ);

  always_comb begin
    if (raw) begin
      cnt_n = (st.settle_count < FULL_COUNT) ? st.settle_count + cnt_t'(1) : st.settle_count;
    end else begin
      cnt_n = (st.settle_count != '0) ? st.settle_count - cnt_t'(1) : st.settle_count;
    end
  end

  assign stable = cnt_n >= FULL_COUNT;

  always_comb begin
    st_next = st;
    ev      = EV_IDLE;

    if (ticking) begin
      if (!scan_due) begin
        if (st.stable_pressed && !st.long_seen && hold_ok) begin
          st_next.long_seen = 1'b1;
        end
      end else begin
        st_next.last_scan_ms   = now_ms;
        st_next.settle_count   = cnt_n;
        st_next.stable_pressed = stable;
        if (stable && !st.stable_pressed) begin
          // The hold time restarts now, so only a zero threshold is met at once.
          st_next.press_start_ms = now_ms;
          st_next.long_seen      = (long_press_ms == '0);
          st_next.pending_event  = post_event(st.pending_event, EV_PRESSED);
        end else if (!stable && st.stable_pressed) begin
          st_next.long_seen = 1'b0;
          st_next.pending_event = post_event(st.pending_event,
                                             st.long_seen ? EV_LONG : EV_RELEASED);
        end else if (stable && !st.long_seen && hold_ok) begin
          st_next.long_seen = 1'b1;
        end
      end
    end

    case (cmd_t'(cmd))
      CMD_READ: begin
        if (st.is_started) begin
          ev                    = st_next.pending_event;
          st_next.pending_event = EV_IDLE;
        end
      end
      CMD_INIT: begin
        if (!st.is_started) begin
          st_next.is_started     = 1'b1;
          st_next.stable_pressed = raw;
          st_next.settle_count   = raw ? FULL_COUNT : '0;
          st_next.press_start_ms = now_ms;
          st_next.last_scan_ms   = now_ms;
          st_next.long_seen      = 1'b0;
          st_next.pending_event  = EV_IDLE;
        end
      end
      default: begin
      end
    endcase
  end

  assign res.event_code        = ev;
  assign res.debounced_pressed = st_next.stable_pressed;
  assign res.raw_pressed       = st_next.is_started && raw;

endmodule
`default_nettype wire

// ----- rtl/core/key_debounce_long_press_unit.sv -----
// Key debouncer with long-press detection: input stage, state and result register.
// Flow: a beat accepted into the input stage is processed once the output register is
// free, and its result is then registered in the output register.
// Throughput: one beat per cycle while out_stall does not hold the output register.
// Reset (rst, synchronous, active high) clears the key state and both valid bits,
// and restores long_press_ms to 500 and pin_inverted to 0.
`default_nettype none
module key_debounce_long_press_unit import kdlp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  cmd,
  input  wire logic [31:0] now_ms,
  input  wire logic        pin_level,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       event_code,
  output logic             debounced_pressed,
  output logic             raw_pressed,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data
);

  logic        in_q_valid;
  logic [1:0]  in_q_cmd;
  logic [31:0] in_q_now;
  logic        in_q_pin;
  logic        proc;
  logic        in_accept;

  logic [31:0] long_press_ms;
  logic        pin_inverted;

  key_state_t  st;
  key_state_t  st_next;
  key_result_t res;

  assign proc      = in_q_valid && (!out_valid || !out_stall);
  assign in_stall  = in_q_valid && !proc;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_accept) begin
      in_q_valid <= 1'b1;
    end else if (proc) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_q_cmd <= cmd;
      in_q_now <= now_ms;
      in_q_pin <= pin_level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ms <= LONG_PRESS_RESET;
      pin_inverted  <= 1'b0;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_LONG_PRESS:   long_press_ms <= cfg_data;
        REG_PIN_INVERTED: pin_inverted  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  kdlp_step u_step (
    .cmd           (in_q_cmd),
    .now_ms        (in_q_now),
    .pin_level     (in_q_pin),
    .long_press_ms (long_press_ms),
    .pin_inverted  (pin_inverted),
    .st            (st),
    .st_next       (st_next),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (proc) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      event_code        <= res.event_code;
      debounced_pressed <= res.debounced_pressed;
      raw_pressed       <= res.raw_pressed;
    end
  end

  // Nothing can be latched before init.
  a_idle_before_init: assert property (@(posedge clk) disable iff (rst)
    !st.is_started |-> (st.pending_event == EV_IDLE && !st.stable_pressed))
    else $error("event or stable press present before init");

  a_count_saturates: assert property (@(posedge clk) disable iff (rst)
    st.settle_count <= CNT_W'(DEBOUNCE_COUNT))
    else $error("debounce count beyond its ceiling");

  // The long-press flag only lives during a stable press.
  a_long_needs_press: assert property (@(posedge clk) disable iff (rst)
    st.long_seen |-> st.stable_pressed)
    else $error("long-press flag set without a stable press");

  a_proc_gives_result: assert property (@(posedge clk) disable iff (rst)
    proc |=> out_valid)
    else $error("processed beat produced no result");

endmodule
`default_nettype wire

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the key debouncer with long-press detection.
module tb;
  import kdlp_pkg::*;

  // Command code three is unused by the block; it must leave the state alone.
  localparam logic [1:0] CMD_SPARE   = 2'd3;
  localparam int         STALL_LIMIT = 2000;
  localparam int         PHASES      = 5;
  localparam int         PHASE_BEATS = 90;

  localparam key_result_t QUIET_UNSTARTED =
    '{event_code: EV_IDLE, debounced_pressed: 1'b0, raw_pressed: 1'b0};
  localparam key_result_t QUIET_RAW_DOWN =
    '{event_code: EV_IDLE, debounced_pressed: 1'b0, raw_pressed: 1'b1};
  localparam key_result_t NO_CLAIM = '0;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] t;
    logic        pin;
    bit          typed;
    key_result_t want;
  } plan_row_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic [1:0]  cmd       = CMD_TICK;
  logic [31:0] now_ms    = '0;
  logic        pin_level = 1'b1;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  event_code;
  logic        debounced_pressed;
  logic        raw_pressed;
  logic        cfg_we    = 1'b0;
  logic        cfg_index = REG_LONG_PRESS;
  logic [31:0] cfg_data  = '0;

  // Predicted key state and the register copies it runs on.
  logic        key_started  = 1'b0;
  logic        key_stable   = 1'b0;
  logic        key_long     = 1'b0;
  logic [31:0] key_press_t  = '0;
  logic [31:0] key_scan_t   = '0;
  int unsigned key_count    = 0;
  event_t      key_pending  = EV_IDLE;
  logic [31:0] key_hold_ms  = LONG_PRESS_RESET;
  logic        key_inverted = 1'b0;

  key_result_t key_results_due[$];
  plan_row_t   directed_plan[$];

  bit sender_gaps   = 1'b1;
  bit receiver_gaps = 1'b1;
  int hold_request  = 0;
  int idle_cycles   = 0;
  int faults        = 0;
  int beats_sent    = 0;
  int results_seen  = 0;
  int events_seen   = 0;
  int long_reports  = 0;

  key_debounce_long_press_unit dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .cmd               (cmd),
    .now_ms            (now_ms),
    .pin_level         (pin_level),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .event_code        (event_code),
    .debounced_pressed (debounced_pressed),
    .raw_pressed       (raw_pressed),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #6 clk = ~clk;

  function void latch_event(event_t ev);
    if (ev == EV_IDLE) return;
    if (key_pending == EV_IDLE) key_pending = ev;
    else if (key_pending == EV_PRESSED) return;
    else if (ev == EV_LONG) key_pending = ev;
    else if (key_pending == EV_RELEASED && ev == EV_PRESSED) key_pending = ev;
  endfunction

  function void mark_long_hold(logic [31:0] t);
    logic [31:0] held;
    held = t - key_press_t;
    if (key_stable && !key_long && held >= key_hold_ms) key_long = 1'b1;
  endfunction

  function void scan_pin(logic [31:0] t, logic down);
    logic [31:0] since;
    logic        steady;
    if (!key_started) return;
    since = t - key_scan_t;
    // Inside the scan interval only the hold timer is looked at.
    if (since < SCAN_INTERVAL_MS) begin
      mark_long_hold(t);
      return;
    end
    key_scan_t = t;
    if (down) begin
      if (key_count < DEBOUNCE_COUNT) key_count++;
    end else if (key_count > 0) begin
      key_count--;
    end
    steady = (key_count >= DEBOUNCE_COUNT);
    if (steady && !key_stable) begin
      key_press_t = t;
      key_long = 1'b0;
      latch_event(EV_PRESSED);
    end else if (!steady && key_stable) begin
      if (key_long) begin
        latch_event(EV_LONG);
        key_long = 1'b0;
      end else begin
        latch_event(EV_RELEASED);
      end
    end
    key_stable = steady;
    mark_long_hold(t);
  endfunction

  function key_result_t debounce_step(logic [1:0] op, logic [31:0] t, logic pin);
    logic        down;
    key_result_t r;
    down = key_inverted ? pin : !pin;
    r.event_code = EV_IDLE;
    case (op)
      CMD_TICK: scan_pin(t, down);
      CMD_READ: begin
        if (key_started) begin
          scan_pin(t, down);
          r.event_code = key_pending;
          key_pending = EV_IDLE;
        end
      end
      CMD_INIT: begin
        if (!key_started) begin
          key_started = 1'b1;
          key_stable  = down;
          key_count   = down ? DEBOUNCE_COUNT : 0;
          key_press_t = t;
          key_scan_t  = t;
          key_long    = 1'b0;
          key_pending = EV_IDLE;
        end
      end
      default: ;
    endcase
    r.debounced_pressed = key_stable;
    r.raw_pressed = key_started && down;
    return r;
  endfunction

  function automatic int pick_gap(bit enabled);
    int roll;
    if (!enabled) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(15, 40);
  endfunction

  function void plan_row(logic [1:0] op, logic [31:0] t, logic pin, bit typed,
                         key_result_t want);
    plan_row_t row;
    row.op = op;
    row.t = t;
    row.pin = pin;
    row.typed = typed;
    row.want = want;
    directed_plan.push_back(row);
  endfunction

  task automatic send_beat(logic [1:0] op, logic [31:0] t, logic pin, bit typed,
                           key_result_t want);
    int          gap;
    key_result_t due;
    gap = pick_gap(sender_gaps);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    cmd       <= op;
    now_ms    <= t;
    pin_level <= pin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // The predictor always runs so that its state follows the block.
    due = debounce_step(op, t, pin);
    key_results_due.push_back(typed ? want : due);
    beats_sent++;
  endtask

  task automatic write_settings(logic [31:0] hold_ms, logic inverted);
    cfg_we    <= 1'b1;
    cfg_index <= REG_LONG_PRESS;
    cfg_data  <= hold_ms;
    @(posedge clk);
    cfg_index <= REG_PIN_INVERTED;
    cfg_data  <= {31'd0, inverted};
    @(posedge clk);
    cfg_we <= 1'b0;
    key_hold_ms = hold_ms;
    key_inverted = inverted;
  endtask

  task automatic wait_drained();
    while (key_results_due.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : drain
    int          hold_left;
    key_result_t want;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        if (key_results_due.size() == 0) begin
          $error("result beat arrived with no expectation waiting");
          faults++;
        end else begin
          want = key_results_due.pop_front();
          if (event_code !== want.event_code) begin
            $error("event_code: expected %0d, got %0d", want.event_code, event_code);
            faults++;
          end
          if (debounced_pressed !== want.debounced_pressed) begin
            $error("debounced_pressed: expected %0d, got %0d",
                   want.debounced_pressed, debounced_pressed);
            faults++;
          end
          if (raw_pressed !== want.raw_pressed) begin
            $error("raw_pressed: expected %0d, got %0d", want.raw_pressed, raw_pressed);
            faults++;
          end
          results_seen++;
          if (want.event_code != EV_IDLE) events_seen++;
          if (want.event_code == EV_LONG) long_reports++;
        end
      end
      if (hold_left == 0 && hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end else if (hold_left == 0) begin
        hold_left = pick_gap(receiver_gaps);
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    logic [31:0] t_cur;
    logic [31:0] hold;
    logic        inv;
    logic        want_down;
    logic        pin;
    logic [1:0]  op;
    int          run_left;
    int          roll;

    // Before init nothing moves; a repeated init is ignored.
    plan_row(CMD_TICK,  32'd0,    1'b1, 1'b1, QUIET_UNSTARTED);
    plan_row(CMD_READ,  32'd100,  1'b0, 1'b1, QUIET_UNSTARTED);
    plan_row(CMD_SPARE, 32'd200,  1'b0, 1'b1, QUIET_UNSTARTED);
    plan_row(CMD_INIT,  32'd1000, 1'b1, 1'b1, QUIET_UNSTARTED);
    plan_row(CMD_INIT,  32'd1004, 1'b0, 1'b1, QUIET_RAW_DOWN);
    // Early tick, then a bounce before the press settles.
    plan_row(CMD_TICK,  32'd1005, 1'b0, 1'b0, NO_CLAIM);
    plan_row(CMD_TICK,  32'd1010, 1'b0, 1'b0, NO_CLAIM);
    plan_row(CMD_TICK,  32'd1020, 1'b1, 1'b0, NO_CLAIM);
    plan_row(CMD_TICK,  32'd1030, 1'b0, 1'b0, NO_CLAIM);
    plan_row(CMD_TICK,  32'd1040, 1'b0, 1'b0, NO_CLAIM);
    plan_row(CMD_TICK,  32'd1050, 1'b0, 1'b0, NO_CLAIM);
    plan_row(CMD_READ,  32'd1055, 1'b0, 1'b0, NO_CLAIM);
    plan_row(CMD_READ,  32'd1056, 1'b0, 1'b0, NO_CLAIM);
    // Held past the long-press time, then released.
    plan_row(CMD_TICK,  32'd1600, 1'b0, 1'b0, NO_CLAIM);
    plan_row(CMD_TICK,  32'd1610, 1'b1, 1'b0, NO_CLAIM);
    plan_row(CMD_TICK,  32'd1620, 1'b1, 1'b0, NO_CLAIM);
    plan_row(CMD_READ,  32'd1630, 1'b1, 1'b0, NO_CLAIM);
    plan_row(CMD_SPARE, 32'd1631, 1'b0, 1'b0, NO_CLAIM);
    // Time wrapping through zero, and a press replacing a pending release.
    plan_row(CMD_TICK,  32'hFFFF_FFFF, 1'b0, 1'b0, NO_CLAIM);
    plan_row(CMD_TICK,  32'h0000_0005, 1'b0, 1'b0, NO_CLAIM);
    plan_row(CMD_TICK,  32'h0000_0009, 1'b0, 1'b0, NO_CLAIM);
    plan_row(CMD_READ,  32'h0000_0013, 1'b0, 1'b0, NO_CLAIM);
    plan_row(CMD_TICK,  32'h7FFF_FFFF, 1'b1, 1'b0, NO_CLAIM);
    plan_row(CMD_TICK,  32'h8000_000A, 1'b0, 1'b0, NO_CLAIM);
    plan_row(CMD_READ,  32'hAAAA_AAAA, 1'b1, 1'b0, NO_CLAIM);

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_plan[i])
      send_beat(directed_plan[i].op, directed_plan[i].t, directed_plan[i].pin,
                directed_plan[i].typed, directed_plan[i].want);
    in_valid <= 1'b0;
    wait_drained();

    t_cur = 32'd5000;
    want_down = 1'b0;
    run_left = 0;
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          hold = 32'd0;
          inv = 1'b1;
        end
        1: begin
          hold = 32'hFFFF_FFFF;
          inv = 1'b0;
          t_cur = 32'hFFFF_FE00;
        end
        2: begin
          hold = $urandom_range(30, 150);
          inv = 1'b1;
        end
        3: begin
          hold = $urandom;
          inv = $urandom_range(0, 1);
        end
        default: begin
          hold = LONG_PRESS_RESET;
          inv = 1'b0;
          t_cur = 32'hFFFF_F000;
        end
      endcase
      write_settings(hold, inv);
      sender_gaps = (ph != 2) && (ph != 3 || $urandom_range(0, 1) == 1);
      receiver_gaps = (ph != 3);
      // A long receiver hold-off while beats keep coming fills the block.
      if (ph == 2) hold_request = 80;

      for (int n = 0; n < PHASE_BEATS; n++) begin
        if (run_left == 0) begin
          want_down = !want_down;
          run_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 70)
                                                 : $urandom_range(1, 6);
        end
        run_left--;
        roll = $urandom_range(0, 99);
        if (roll < 4) t_cur = $urandom;
        else if (roll < 20) t_cur += $urandom_range(1, 9);
        else if (roll < 22) t_cur += $urandom_range(1000, 100000);
        else t_cur += $urandom_range(10, 13);
        pin = ~(want_down ^ key_inverted);
        if ($urandom_range(0, 9) == 0) pin = ~pin;
        roll = $urandom_range(0, 99);
        if (roll < 25) op = CMD_READ;
        else if (roll < 27) op = CMD_INIT;
        else if (roll < 29) op = CMD_SPARE;
        else op = CMD_TICK;
        send_beat(op, t_cur, pin, 1'b0, NO_CLAIM);
      end
      in_valid <= 1'b0;
      wait_drained();
    end

    repeat (6) @(posedge clk);
    $display("Sent %0d key beats and checked %0d results; %0d reads carried an event,",
             beats_sent, results_seen, events_seen);
    $display("%0d of them long presses, over %0d register settings and a time wrap.",
             long_reports, PHASES);
    if (faults == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
